// ----- rtl/psl_pkg.sv -----
`default_nettype none

package psl_pkg;

    // Field widths
    localparam int POS_WIDTH = 31;
    localparam int HEAD_W    = 16;
    localparam int TSTEP_W   = 16;
    localparam int SPEED_W   = 24;
    localparam int YAWR_W    = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Distance normalization: magnitudes are scaled down to at most NORM_BITS bits
    localparam int NORM_BITS = 31;
    localparam int MAG_W     = POS_WIDTH;
    localparam int A_W       = (MAG_W < NORM_BITS) ? MAG_W : NORM_BITS;
    localparam int S_MAX     = (MAG_W > NORM_BITS) ? MAG_W - NORM_BITS : 0;
    localparam int S_W       = (S_MAX > 0) ? $clog2(S_MAX + 1) : 1;

    // Square root and divider widths
    localparam int ROOT_W    = A_W + 1;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int LIM_W     = SPEED_W;
    localparam int PROD_W    = A_W + LIM_W;
    localparam int QUO_W     = LIM_W;
    localparam int EXT_W     = ((POS_WIDTH > LIM_W) ? POS_WIDTH : LIM_W) + 2;
    localparam int CMP_W     = ((ROOT_W > LIM_W) ? ROOT_W : LIM_W) + 1;

    // Pipeline depths
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUO_W;

    // Yaw half turn
    localparam logic [HEAD_W-1:0] HALF_TURN = 16'h8000;

    // Stream packing, first field in the lowest bits
    localparam int IN_CX   = 0;
    localparam int IN_CY   = IN_CX + POS_WIDTH;
    localparam int IN_CZ   = IN_CY + POS_WIDTH;
    localparam int IN_CH   = IN_CZ + POS_WIDTH;
    localparam int IN_GX   = IN_CH + HEAD_W;
    localparam int IN_GY   = IN_GX + POS_WIDTH;
    localparam int IN_GZ   = IN_GY + POS_WIDTH;
    localparam int IN_GH   = IN_GZ + POS_WIDTH;
    localparam int IN_DT   = IN_GH + HEAD_W;
    localparam int IN_BITS = IN_DT + TSTEP_W;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_NX   = 0;
    localparam int OUT_NY   = OUT_NX + POS_WIDTH;
    localparam int OUT_NZ   = OUT_NY + POS_WIDTH;
    localparam int OUT_NH   = OUT_NZ + POS_WIDTH;
    localparam int OUT_BITS = OUT_NH + HEAD_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HSPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VSPEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAWRATE = 2'd2;

    localparam logic [SPEED_W-1:0] HSPEED_RST  = 24'd65536;
    localparam logic [SPEED_W-1:0] VSPEED_RST  = 24'd32768;
    localparam logic [YAWR_W-1:0]  YAWRATE_RST = 16'd8192;

    // Per-item data carried beside the arithmetic
    typedef struct packed {
        logic                        sx;
        logic                        sy;
        logic signed [POS_WIDTH-1:0] cx;
        logic signed [POS_WIDTH-1:0] cy;
        logic signed [POS_WIDTH-1:0] gx;
        logic signed [POS_WIDTH-1:0] gy;
        logic signed [POS_WIDTH-1:0] nz;
        logic [HEAD_W-1:0]           nh;
    } t_pass;

    typedef struct packed {
        t_pass             p;
        logic [LIM_W-1:0]  hs;
        logic [PROD_W-1:0] ah;
        logic [PROD_W-1:0] bh;
    } t_side;

    typedef struct packed {
        logic  reach;
        t_pass p;
    } t_post;

endpackage

`default_nettype wire

// ----- rtl/pose_setpoint_slew_limiter.sv -----
// Rate-limited setpoint generator for x, y, z and yaw. Each input transfer
// carries the current setpoint, the goal pose and a time step; one output
// transfer returns the next setpoint. x/y move along the straight line to the
// goal by at most the horizontal speed limit times the time step, z by at most
// the vertical speed limit times the time step, yaw the shortest way round by
// at most the yaw rate limit times the time step.
// The block is fully pipelined and takes one transfer per clock while the
// output is not stalled. The horizontal distance and the partial move come
// from the 32-stage square root and the 24-stage divider. A one-entry skid
// buffer at the input lets one more transfer in while a result is held.
// The user must write registers through the cfg port only while no item is
// in flight; the block itself does not enforce this.
`default_nettype none

module pose_setpoint_slew_limiter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [psl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [psl_pkg::CFG_W-1:0]       i_cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cur_x, cur_y, cur_z, cur_heading, goal_x, goal_y, goal_z, goal_heading,
    // time_step, zero pad
    input  wire logic [psl_pkg::IN_W-1:0]        s_axis_tdata,
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // next_x, next_y, next_z, next_heading, zero pad
    output logic      [psl_pkg::OUT_W-1:0]       m_axis_tdata
);
    import psl_pkg::*;

    // Config registers
    logic [SPEED_W-1:0] r_hspeed, r_vspeed;
    logic [YAWR_W-1:0]  r_yawrate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hspeed  <= HSPEED_RST;
            r_vspeed  <= VSPEED_RST;
            r_yawrate <= YAWRATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HSPEED:  r_hspeed  <= i_cfg_data[SPEED_W-1:0];
                REG_VSPEED:  r_vspeed  <= i_cfg_data[SPEED_W-1:0];
                REG_YAWRATE: r_yawrate <= i_cfg_data[YAWR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance and input skid
    logic            en;
    logic            in_xfer;
    logic            r_skid_vld;
    logic [IN_W-1:0] r_skid_data;
    logic [IN_W-1:0] src;
    logic            src_vld;
    logic            r_out_vld;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_skid_vld;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign src           = r_skid_vld ? r_skid_data : s_axis_tdata;
    assign src_vld       = r_skid_vld || in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (en) begin
            r_skid_vld <= 1'b0;
        end else if (in_xfer) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && !en) begin
            r_skid_data <= s_axis_tdata;
        end
    end

    // Front stages
    logic            f_vld;
    logic [SQ_W-1:0] f_rad;
    t_side           f_side;

    psl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_vld          (src_vld),
        .i_cur_x        (src[IN_CX +: POS_WIDTH]),
        .i_cur_y        (src[IN_CY +: POS_WIDTH]),
        .i_cur_z        (src[IN_CZ +: POS_WIDTH]),
        .i_cur_heading  (src[IN_CH +: HEAD_W]),
        .i_goal_x       (src[IN_GX +: POS_WIDTH]),
        .i_goal_y       (src[IN_GY +: POS_WIDTH]),
        .i_goal_z       (src[IN_GZ +: POS_WIDTH]),
        .i_goal_heading (src[IN_GH +: HEAD_W]),
        .i_time_step    (src[IN_DT +: TSTEP_W]),
        .i_hspeed       (r_hspeed),
        .i_vspeed       (r_vspeed),
        .i_yawrate      (r_yawrate),
        .o_vld          (f_vld),
        .o_radicand     (f_rad),
        .o_side         (f_side)
    );

    // Distance
    logic [ROOT_W-1:0] root;

    psl_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (f_rad),
        .o_root     (root)
    );

    // Side data alongside the square root
    logic [SQRT_LAT-1:0] r_sq_vld;
    t_side               r_sq_side [SQRT_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
        end else if (en) begin
            r_sq_vld <= {r_sq_vld[SQRT_LAT-2:0], f_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_side[0] <= f_side;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // Reach test: goal within this step's horizontal limit
    t_side             sq_out;
    logic              r5_vld;
    t_post             r5_post;
    logic [PROD_W-1:0] r5_ah, r5_bh;
    logic [ROOT_W-1:0] r5_root;

    assign sq_out = r_sq_side[SQRT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r_sq_vld[SQRT_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_post.reach <= (root == '0) || (CMP_W'(sq_out.hs) >= CMP_W'(root));
            r5_post.p     <= sq_out.p;
            r5_ah         <= sq_out.ah;
            r5_bh         <= sq_out.bh;
            r5_root       <= root;
        end
    end

    // Partial move along each axis
    logic [QUO_W-1:0] qx, qy;

    psl_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r5_ah),
        .i_divisor  (r5_root),
        .o_quot     (qx)
    );

    psl_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r5_bh),
        .i_divisor  (r5_root),
        .o_quot     (qy)
    );

    logic [DIV_LAT-1:0] r_dv_vld;
    t_post              r_dv_post [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
        end else if (en) begin
            r_dv_vld <= {r_dv_vld[DIV_LAT-2:0], r5_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_post[0] <= r5_post;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dv_post[k] <= r_dv_post[k-1];
            end
        end
    end

    // Output register
    t_post            dv_out;
    logic [EXT_W-1:0] cx_e, cy_e, mx_e, my_e, nx_e, ny_e;
    logic [OUT_W-1:0] n_out_data;
    logic [OUT_W-1:0] r_out_data;

    assign dv_out = r_dv_post[DIV_LAT-1];

    always_comb begin
        cx_e = EXT_W'(dv_out.p.cx);
        cy_e = EXT_W'(dv_out.p.cy);
        mx_e = EXT_W'(qx);
        my_e = EXT_W'(qy);
        nx_e = dv_out.p.sx ? (cx_e - mx_e) : (cx_e + mx_e);
        ny_e = dv_out.p.sy ? (cy_e - my_e) : (cy_e + my_e);

        n_out_data = '0;
        n_out_data[OUT_NX +: POS_WIDTH] = dv_out.reach ? dv_out.p.gx : nx_e[POS_WIDTH-1:0];
        n_out_data[OUT_NY +: POS_WIDTH] = dv_out.reach ? dv_out.p.gy : ny_e[POS_WIDTH-1:0];
        n_out_data[OUT_NZ +: POS_WIDTH] = dv_out.p.nz;
        n_out_data[OUT_NH +: HEAD_W]    = dv_out.p.nh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- rtl/psl_front.sv -----
`default_nettype none

module psl_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_vld,
    input  wire logic signed [psl_pkg::POS_WIDTH-1:0] i_cur_x,
    input  wire logic signed [psl_pkg::POS_WIDTH-1:0] i_cur_y,
    input  wire logic signed [psl_pkg::POS_WIDTH-1:0] i_cur_z,
    input  wire logic        [psl_pkg::HEAD_W-1:0]    i_cur_heading,
    input  wire logic signed [psl_pkg::POS_WIDTH-1:0] i_goal_x,
    input  wire logic signed [psl_pkg::POS_WIDTH-1:0] i_goal_y,
    input  wire logic signed [psl_pkg::POS_WIDTH-1:0] i_goal_z,
    input  wire logic        [psl_pkg::HEAD_W-1:0]    i_goal_heading,
    input  wire logic        [psl_pkg::TSTEP_W-1:0]   i_time_step,
    input  wire logic        [psl_pkg::SPEED_W-1:0]   i_hspeed,
    input  wire logic        [psl_pkg::SPEED_W-1:0]   i_vspeed,
    input  wire logic        [psl_pkg::YAWR_W-1:0]    i_yawrate,
    output logic                                      o_vld,
    output logic             [psl_pkg::SQ_W-1:0]      o_radicand,
    output psl_pkg::t_side                            o_side
);
    import psl_pkg::*;

    logic [3:0] r_vld;

    // Stage 1: differences and step limits
    logic [SPEED_W+TSTEP_W-1:0] n1_hprod;
    logic [SPEED_W+TSTEP_W-1:0] n1_vprod;
    logic [YAWR_W+TSTEP_W-1:0]  n1_yprod;
    logic signed [POS_WIDTH:0]  r1_dx, r1_dy, r1_dz;
    logic signed [POS_WIDTH-1:0] r1_cx, r1_cy, r1_cz, r1_gx, r1_gy, r1_gz;
    logic [HEAD_W-1:0]          r1_ch, r1_dd;
    logic [LIM_W-1:0]           r1_h, r1_v;
    logic [YAWR_W-1:0]          r1_ys;

    assign n1_hprod = i_hspeed * i_time_step;
    assign n1_vprod = i_vspeed * i_time_step;
    assign n1_yprod = i_yawrate * i_time_step;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= (POS_WIDTH+1)'(i_goal_x) - (POS_WIDTH+1)'(i_cur_x);
            r1_dy <= (POS_WIDTH+1)'(i_goal_y) - (POS_WIDTH+1)'(i_cur_y);
            r1_dz <= (POS_WIDTH+1)'(i_goal_z) - (POS_WIDTH+1)'(i_cur_z);
            r1_cx <= i_cur_x;
            r1_cy <= i_cur_y;
            r1_cz <= i_cur_z;
            r1_gx <= i_goal_x;
            r1_gy <= i_goal_y;
            r1_gz <= i_goal_z;
            r1_ch <= i_cur_heading;
            r1_dd <= i_goal_heading - i_cur_heading;
            r1_h  <= n1_hprod[SPEED_W+TSTEP_W-1:TSTEP_W];
            r1_v  <= n1_vprod[SPEED_W+TSTEP_W-1:TSTEP_W];
            r1_ys <= n1_yprod[YAWR_W+TSTEP_W-1:TSTEP_W];
        end
    end

    // Stage 2: magnitudes, normalization, z and yaw results
    logic signed [POS_WIDTH:0] n2_negx, n2_negy, n2_negz;
    logic [MAG_W-1:0]  n2_ax, n2_ay, n2_azm, n2_mag;
    logic [S_W-1:0]    n2_s;
    logic [EXT_W-1:0]  n2_zm_e, n2_v_e, n2_cz_e, n2_zstep;
    logic              n2_dneg;
    logic [HEAD_W-1:0] n2_dmag, n2_move;
    t_pass             n2_pass;
    logic [A_W-1:0]    r2_a, r2_b;
    logic [S_W-1:0]    r2_s;
    logic [LIM_W-1:0]  r2_h;
    t_pass             r2_pass;

    always_comb begin
        n2_negx = -r1_dx;
        n2_negy = -r1_dy;
        n2_negz = -r1_dz;
        n2_ax   = r1_dx[POS_WIDTH] ? n2_negx[MAG_W-1:0] : r1_dx[MAG_W-1:0];
        n2_ay   = r1_dy[POS_WIDTH] ? n2_negy[MAG_W-1:0] : r1_dy[MAG_W-1:0];
        n2_azm  = r1_dz[POS_WIDTH] ? n2_negz[MAG_W-1:0] : r1_dz[MAG_W-1:0];
        n2_mag  = (n2_ax > n2_ay) ? n2_ax : n2_ay;

        // smallest shift that brings the larger magnitude into A_W bits
        n2_s = S_W'(S_MAX);
        for (int k = S_MAX; k >= 0; k--) begin
            if (((n2_mag >> k) >> A_W) == '0) begin
                n2_s = S_W'(k);
            end
        end

        // z: step by the limit unless the goal is within reach
        n2_zm_e  = EXT_W'(n2_azm);
        n2_v_e   = EXT_W'(r1_v);
        n2_cz_e  = EXT_W'(r1_cz);
        n2_zstep = r1_dz[POS_WIDTH] ? (n2_cz_e - n2_v_e) : (n2_cz_e + n2_v_e);

        // yaw: shortest way round, half turn counts as positive
        n2_dneg = (r1_dd > HALF_TURN);
        n2_dmag = n2_dneg ? (HEAD_W'(0) - r1_dd) : r1_dd;
        n2_move = (n2_dmag < r1_ys) ? n2_dmag : r1_ys;

        n2_pass.sx = r1_dx[POS_WIDTH];
        n2_pass.sy = r1_dy[POS_WIDTH];
        n2_pass.cx = r1_cx;
        n2_pass.cy = r1_cy;
        n2_pass.gx = r1_gx;
        n2_pass.gy = r1_gy;
        n2_pass.nz = (n2_zm_e <= n2_v_e) ? r1_gz : n2_zstep[POS_WIDTH-1:0];
        n2_pass.nh = n2_dneg ? (r1_ch - n2_move) : (r1_ch + n2_move);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a    <= A_W'(n2_ax >> n2_s);
            r2_b    <= A_W'(n2_ay >> n2_s);
            r2_s    <= n2_s;
            r2_h    <= r1_h;
            r2_pass <= n2_pass;
        end
    end

    // Stage 3: squares and scaled moves
    logic [2*A_W-1:0]  r3_aa, r3_bb;
    logic [PROD_W-1:0] r3_ah, r3_bh;
    logic [LIM_W-1:0]  r3_hs;
    t_pass             r3_pass;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_aa   <= r2_a * r2_a;
            r3_bb   <= r2_b * r2_b;
            r3_ah   <= r2_a * r2_h;
            r3_bh   <= r2_b * r2_h;
            r3_hs   <= r2_h >> r2_s;
            r3_pass <= r2_pass;
        end
    end

    // Stage 4: radicand
    logic [SQ_W-1:0] r4_rad;
    t_side           r4_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_rad       <= SQ_W'(r3_aa) + SQ_W'(r3_bb);
            r4_side.p    <= r3_pass;
            r4_side.hs   <= r3_hs;
            r4_side.ah   <= r3_ah;
            r4_side.bh   <= r3_bh;
        end
    end

    // Valid bits follow the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    assign o_vld      = r_vld[3];
    assign o_radicand = r4_rad;
    assign o_side     = r4_side;

endmodule

`default_nettype wire

// ----- rtl/psl_isqrt.sv -----
`default_nettype none

// Pipelined integer square root, one result bit per stage
module psl_isqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [psl_pkg::SQ_W-1:0]     i_radicand,
    output logic      [psl_pkg::ROOT_W-1:0]   o_root
);
    import psl_pkg::*;

    logic [SQ_W-1:0]   r_rad  [ROOT_W];
    logic [ROOT_W+1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [SQ_W-1:0]   n_rad_in;
        logic [ROOT_W+1:0] n_rem_in;
        logic [ROOT_W-1:0] n_root_in;
        logic [ROOT_W+1:0] n_cur, n_trial;
        logic              n_take;

        if (k == 0) begin : g_first
            assign n_rad_in  = i_radicand;
            assign n_rem_in  = '0;
            assign n_root_in = '0;
        end else begin : g_next
            assign n_rad_in  = r_rad[k-1];
            assign n_rem_in  = r_rem[k-1];
            assign n_root_in = r_root[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign n_cur   = {n_rem_in[ROOT_W-1:0], n_rad_in[SQ_W-1:SQ_W-2]};
        assign n_trial = {n_root_in, 2'b01};
        assign n_take  = (n_cur >= n_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= n_rad_in << 2;
                r_rem[k]  <= n_take ? (n_cur - n_trial) : n_cur;
                r_root[k] <= {n_root_in[ROOT_W-2:0], n_take};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/psl_div.sv -----
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit QUO_W bits (dividend < divisor << QUO_W).
module psl_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [psl_pkg::PROD_W-1:0]   i_dividend,
    input  wire logic [psl_pkg::ROOT_W-1:0]   i_divisor,
    output logic      [psl_pkg::QUO_W-1:0]    o_quot
);
    import psl_pkg::*;

    logic [ROOT_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0]  r_lo  [QUO_W];
    logic [ROOT_W-1:0] r_dvs [QUO_W];
    logic [QUO_W-1:0]  r_quo [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [ROOT_W-1:0] n_rem_in, n_dvs_in;
        logic [QUO_W-1:0]  n_lo_in, n_quo_in;
        logic [ROOT_W:0]   n_cur, n_diff;
        logic              n_take;

        if (j == 0) begin : g_first
            assign n_rem_in = ROOT_W'(i_dividend[PROD_W-1:QUO_W]);
            assign n_lo_in  = i_dividend[QUO_W-1:0];
            assign n_dvs_in = i_divisor;
            assign n_quo_in = '0;
        end else begin : g_next
            assign n_rem_in = r_rem[j-1];
            assign n_lo_in  = r_lo[j-1];
            assign n_dvs_in = r_dvs[j-1];
            assign n_quo_in = r_quo[j-1];
        end

        assign n_cur  = {n_rem_in, n_lo_in[QUO_W-1]};
        assign n_take = (n_cur >= {1'b0, n_dvs_in});
        assign n_diff = n_cur - {1'b0, n_dvs_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_take ? n_diff[ROOT_W-1:0] : n_cur[ROOT_W-1:0];
                r_lo[j]  <= n_lo_in << 1;
                r_dvs[j] <= n_dvs_in;
                r_quo[j] <= {n_quo_in[QUO_W-2:0], n_take};
            end
        end
    end

    assign o_quot = r_quo[QUO_W-1];

endmodule

`default_nettype wire

// ----- rtl/psl_chk.sv -----
`default_nettype none

module psl_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [psl_pkg::OUT_W-1:0] m_axis_tdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Input backpressure only follows an output stall
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input ready dropped without output stall");

    // Held input drains as soon as the output moves
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("skid entry not drained");

endmodule

bind pose_setpoint_slew_limiter psl_chk u_psl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import psl_pkg::*;

    localparam int LAT      = 62;
    localparam int CYC_MAX  = 900000;
    localparam int HOLD_LEN = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [TSTEP_W-1:0]          dt;
        logic [HEAD_W-1:0]           gh;
        logic signed [POS_WIDTH-1:0] gz;
        logic signed [POS_WIDTH-1:0] gy;
        logic signed [POS_WIDTH-1:0] gx;
        logic [HEAD_W-1:0]           ch;
        logic signed [POS_WIDTH-1:0] cz;
        logic signed [POS_WIDTH-1:0] cy;
        logic signed [POS_WIDTH-1:0] cx;
    } t_pose_req;

    typedef struct packed {
        logic [HEAD_W-1:0]           nh;
        logic signed [POS_WIDTH-1:0] nz;
        logic signed [POS_WIDTH-1:0] ny;
        logic signed [POS_WIDTH-1:0] nx;
    } t_pose_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;

    pose_setpoint_slew_limiter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor copy of the registers
    logic [SPEED_W-1:0] hspeed;
    logic [SPEED_W-1:0] vspeed;
    logic [YAWR_W-1:0]  yawrate;

    t_pose_req pending_q[$];
    t_pose_res setpoint_q[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_req = 0;
    int  hold_ack = 0;
    int  hold_cycles = 0;
    bit  send_hold;
    int  mismatches = 0;
    int  results_seen = 0;
    int  cycles = 0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Next setpoint from the current one, the goal and the time step
    function automatic t_pose_res next_setpoint(input t_pose_req q);
        t_pose_res   o;
        logic [63:0] hl, vl, yl, ax, ay, mag, a, b, r, mx, my, dzm, dd, dm, mv;
        longint      cx, cy, cz, gx, gy, gz, dx, dy;
        int          s;
        bit          neg;
        cx = longint'(q.cx); cy = longint'(q.cy); cz = longint'(q.cz);
        gx = longint'(q.gx); gy = longint'(q.gy); gz = longint'(q.gz);
        hl = (64'(hspeed) * 64'(q.dt)) >> 16;
        vl = (64'(vspeed) * 64'(q.dt)) >> 16;
        yl = (64'(yawrate) * 64'(q.dt)) >> 16;
        dx = gx - cx;
        dy = gy - cy;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        mag = ax > ay ? ax : ay;
        s = 0;
        while ((mag >> s) >= (64'd1 << NORM_BITS)) s++;
        a = ax >> s;
        b = ay >> s;
        r = root_floor(a * a + b * b);
        if (r == 0 || (hl >> s) >= r) begin
            o.nx = POS_WIDTH'(gx);
            o.ny = POS_WIDTH'(gy);
        end else begin
            mx = (a * hl) / r;
            my = (b * hl) / r;
            o.nx = POS_WIDTH'(dx < 0 ? cx - longint'(mx) : cx + longint'(mx));
            o.ny = POS_WIDTH'(dy < 0 ? cy - longint'(my) : cy + longint'(my));
        end
        dzm = gz > cz ? gz - cz : cz - gz;
        if (dzm <= vl) o.nz = POS_WIDTH'(gz);
        else o.nz = POS_WIDTH'(gz < cz ? cz - longint'(vl) : cz + longint'(vl));
        // Shortest turn; exactly a half turn goes positive
        dd = 64'(16'(q.gh - q.ch));
        neg = dd > 64'(HALF_TURN);
        dm = neg ? 64'h10000 - dd : dd;
        mv = dm < yl ? dm : yl;
        o.nh = neg ? q.ch - 16'(mv) : q.ch + 16'(mv);
        return o;
    endfunction

    // Driver: offers queued items, predicts at each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                setpoint_q.push_back(next_setpoint(pending_q.pop_front()));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold current item
            end else if (pending_q.size() > 0
                         && !send_hold && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_W'(pending_q[0]);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready pattern, with a long hold-off counted here on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_cycles   <= HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Monitor: compares each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_pose_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_pose_res'(m_axis_tdata[OUT_BITS-1:0]);
            results_seen++;
            if (setpoint_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = setpoint_q.pop_front();
                if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz
                    || got.nh !== want.nh) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: want x=%0d y=%0d z=%0d h=%h, got x=%0d y=%0d z=%0d h=%h",
                                 results_seen, want.nx, want.ny, want.nz, want.nh,
                                 got.nx, got.ny, got.nz, got.nh);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [POS_WIDTH-1:0] rand_pos();
        case ($urandom_range(5))
            0: return {1'b0, {(POS_WIDTH-1){1'b1}}};
            1: return {1'b1, {(POS_WIDTH-1){1'b0}}};
            2: return POS_WIDTH'(int'($urandom_range(2000)) - 1000);
            3: return POS_WIDTH'(int'($urandom_range(2000000)) - 1000000);
            default: return POS_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_pose_req rand_req();
        t_pose_req q;
        q.cx = rand_pos(); q.cy = rand_pos(); q.cz = rand_pos();
        q.ch = 16'($urandom);
        // Goals often near the current point so partial moves and reach both occur
        q.gx = $urandom_range(1) ? rand_pos() : q.cx + POS_WIDTH'(int'($urandom_range(400000)) - 200000);
        q.gy = $urandom_range(1) ? rand_pos() : q.cy + POS_WIDTH'(int'($urandom_range(400000)) - 200000);
        q.gz = $urandom_range(1) ? rand_pos() : q.cz + POS_WIDTH'(int'($urandom_range(400000)) - 200000);
        case ($urandom_range(3))
            0: q.gh = q.ch + HALF_TURN;
            1: q.gh = q.ch + 16'(int'($urandom_range(4000)) - 2000);
            default: q.gh = 16'($urandom);
        endcase
        q.dt = $urandom_range(3) == 0 ? 16'($urandom_range(3)) : 16'($urandom);
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_axis_tvalid || setpoint_q.size() != 0)
            @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_HSPEED:  hspeed  = val;
            REG_VSPEED:  vspeed  = val;
            REG_YAWRATE: yawrate = YAWR_W'(val);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) pending_q.push_back(rand_req());
        wait_drained();
    endtask

    initial begin
        t_pose_req q;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; send_hold = 0;
        hspeed = HSPEED_RST; vspeed = VSPEED_RST; yawrate = YAWRATE_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, reach, half turn, zero step, at reset values
        q = '0; pending_q.push_back(q);
        q.cx = {1'b1, {(POS_WIDTH-1){1'b0}}}; q.gx = {1'b0, {(POS_WIDTH-1){1'b1}}};
        q.cy = q.gx; q.gy = q.cx; q.cz = q.cx; q.gz = q.gx;
        q.ch = 16'h8000; q.gh = 16'h7fff; q.dt = 16'hffff;
        pending_q.push_back(q);
        q.dt = 16'd0; pending_q.push_back(q);
        q = '0; q.gh = HALF_TURN; q.dt = 16'hffff; pending_q.push_back(q);
        q.ch = 16'h1234; q.gh = 16'h1234 + HALF_TURN; pending_q.push_back(q);
        q.gh = 16'h1234 + 16'h8001; pending_q.push_back(q);
        q = '0; q.gx = POS_WIDTH'(100); q.gy = POS_WIDTH'(-200); q.gz = POS_WIDTH'(-5);
        q.dt = 16'hffff; pending_q.push_back(q);
        q.gx = POS_WIDTH'(3000000); q.gy = POS_WIDTH'(4000000); q.gz = POS_WIDTH'(900000);
        q.dt = 16'h4000;
        pending_q.push_back(q);
        q.dt = 16'd1; pending_q.push_back(q);
        wait_drained();

        // Register extremes, including an ignored index
        write_reg(REG_HSPEED, 24'hffffff);
        write_reg(REG_VSPEED, 24'hffffff);
        write_reg(REG_YAWRATE, 24'h00ffff);
        write_reg(REG_UNUSED, 24'h123456);
        q = '0; q.cx = {1'b1, {(POS_WIDTH-1){1'b0}}}; q.gx = {1'b0, {(POS_WIDTH-1){1'b1}}};
        q.cy = q.gx; q.gy = q.cx; q.gz = q.gx; q.gh = HALF_TURN; q.dt = 16'hffff;
        pending_q.push_back(q);
        q.dt = 16'h0100; pending_q.push_back(q);
        run_phase(150, 0, 0);

        write_reg(REG_HSPEED, 24'd1);
        write_reg(REG_VSPEED, 24'd1);
        write_reg(REG_YAWRATE, 24'd1);
        run_phase(150, 67, 0);

        write_reg(REG_HSPEED, 24'($urandom_range(1, 24'hffffff)));
        write_reg(REG_VSPEED, 24'($urandom_range(1, 4000000)));
        write_reg(REG_YAWRATE, 24'($urandom_range(1, 65535)));
        run_phase(200, 0, 67);

        write_reg(REG_HSPEED, 24'd200000);
        write_reg(REG_VSPEED, 24'd50000);
        write_reg(REG_YAWRATE, 24'd30000);
        run_phase(200, 20, 20);

        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_req = hold_req + 1;
        repeat (150) pending_q.push_back(rand_req());
        wait_drained();

        // Sender pauses, resumes briefly, then pauses until all results are back, then resumes
        send_hold = 1;
        repeat (100) pending_q.push_back(rand_req());
        repeat (40) @(posedge i_clk);
        send_hold = 0;
        recv_stall_pct = 30;
        repeat (20) @(posedge i_clk);
        send_hold = 1;
        while (setpoint_q.size() != 0) @(posedge i_clk);
        send_hold = 0;
        run_phase(100, 10, 10);

        $display("Covered %0d setpoint results over five register settings, with idle,",
                 results_seen);
        $display("stall and long back-pressure phases.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/psl_pkg.sv
rtl/psl_front.sv
rtl/psl_isqrt.sv
rtl/psl_div.sv
rtl/pose_setpoint_slew_limiter.sv
rtl/psl_chk.sv
bench/tb.sv
